[rtl/i2csbe_pkg.sv]
// Package for the I2C slave bit engine: bus phase codes, state and result
// structs, transmit index width. No dependencies.
`default_nettype none

package i2csbe_pkg;

    // width of the transmit index counter (1 to 8)
    localparam int unsigned TX_INDEX_BITS = 5;
    // width of the reported transmit index field
    localparam int unsigned TX_INDEX_OUT_BITS = 5;

    // opcode of an input word
    localparam logic OP_SCL_EDGE = 1'b0;
    localparam logic OP_SDA_EDGE = 1'b1;

    // bus phase codes as reported on bus_phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_ACK   = 3'd3,
        PH_NACK  = 3'd4
    } t_phase;

    // engine state carried from one word to the next
    typedef struct packed {
        t_phase                   phase;
        logic [3:0]               bit_count;
        logic [7:0]               shift_byte;
        logic                     read_mode;
        logic                     match_flag;
        logic                     first_byte;
        logic [TX_INDEX_BITS-1:0] transmit_index;
        logic                     drive_enable;
        logic                     drive_level;
    } t_state;

    // one result word
    typedef struct packed {
        logic                         sda_drive;
        logic                         sda_out;
        logic                         rx_valid;
        logic [7:0]                   rx_byte;
        logic [TX_INDEX_OUT_BITS-1:0] tx_index;
        logic                         stop_seen;
        logic                         addressed;
        logic [2:0]                   bus_phase;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:          PH_IDLE,
        bit_count:      4'd0,
        shift_byte:     8'd0,
        read_mode:      1'b0,
        match_flag:     1'b0,
        first_byte:     1'b1,
        transmit_index: '0,
        drive_enable:   1'b0,
        drive_level:    1'b1
    };

endpackage

`default_nettype wire

[rtl/i2csbe_ifs.sv]
// Valid/ready channel interfaces of the I2C slave bit engine: event input,
// result output and address configuration. No dependencies.
`default_nettype none

// bus edge event channel
interface i2csbe_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic       scl_level;
    logic       sda_level;
    logic [7:0] tx_data;

    modport source (output valid, opcode, scl_level, sda_level, tx_data, input ready);
    modport sink   (input valid, opcode, scl_level, sda_level, tx_data, output ready);
endinterface

// result channel
interface i2csbe_out_if;
    logic       valid;
    logic       ready;
    logic       sda_drive;
    logic       sda_out;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [4:0] tx_index;
    logic       stop_seen;
    logic       addressed;
    logic [2:0] bus_phase;

    modport source (output valid, sda_drive, sda_out, rx_valid, rx_byte, tx_index,
                    stop_seen, addressed, bus_phase, input ready);
    modport sink   (input valid, sda_drive, sda_out, rx_valid, rx_byte, tx_index,
                    stop_seen, addressed, bus_phase, output ready);
endinterface

// own address write channel
interface i2csbe_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/i2csbe_step.sv]
// Next-state and result logic of the I2C slave bit engine for one bus event.
// Uses i2csbe_pkg.
`default_nettype none

module i2csbe_step (
    input  var i2csbe_pkg::t_state  i_state,
    input  var logic [6:0]          i_own_address,
    input  var logic                i_opcode,
    input  var logic                i_scl_level,
    input  var logic                i_sda_level,
    input  var logic [7:0]          i_tx_data,
    output var i2csbe_pkg::t_state  o_state,
    output var i2csbe_pkg::t_result o_result
);

    i2csbe_pkg::t_state n_state;
    logic               n_rx_valid;
    logic [7:0]         n_rx_byte;
    logic               n_stop;
    logic [3:0]         n_count;
    logic [i2csbe_pkg::TX_INDEX_BITS+4:0] n_index_wide;

    // event decode and state update
    always_comb begin
        n_state    = i_state;
        n_rx_valid = 1'b0;
        n_rx_byte  = 8'd0;
        n_stop     = 1'b0;
        n_count    = i_state.bit_count + 4'd1;

        if (i_opcode == i2csbe_pkg::OP_SCL_EDGE) begin
            if (i_scl_level) begin
                // scl rise: sample sda
                if (i_state.phase == i2csbe_pkg::PH_DATA) begin
                    if (!i_state.read_mode && !i_state.bit_count[3] && i_sda_level) begin
                        n_state.shift_byte[3'd7 - i_state.bit_count[2:0]] = 1'b1;
                    end
                end else if (i_state.phase == i2csbe_pkg::PH_ACK) begin
                    if (i_state.read_mode && i_sda_level) begin
                        n_state.phase = i2csbe_pkg::PH_NACK;
                    end
                end
            end else begin
                // scl fall: advance the bit engine
                case (i_state.phase)
                    i2csbe_pkg::PH_START: begin
                        n_state.bit_count      = 4'd0;
                        n_state.first_byte     = 1'b1;
                        n_state.transmit_index = '0;
                        n_state.match_flag     = 1'b0;
                        n_state.shift_byte     = 8'd0;
                        n_state.read_mode      = 1'b0;
                        n_state.phase          = i2csbe_pkg::PH_DATA;
                    end
                    i2csbe_pkg::PH_DATA: begin
                        n_state.bit_count = n_count;
                        if (!n_count[3]) begin
                            if (i_state.read_mode) begin
                                n_state.drive_level = i_tx_data[3'd7 - n_count[2:0]];
                            end
                        end else if (n_count == 4'd8) begin
                            if (!i_state.read_mode) begin
                                if (i_state.first_byte) begin
                                    if (i_state.shift_byte[7:1] == i_own_address) begin
                                        n_state.match_flag = 1'b1;
                                        n_state.read_mode  = i_state.shift_byte[0];
                                    end
                                end else if (i_state.match_flag) begin
                                    n_rx_valid = 1'b1;
                                    n_rx_byte  = i_state.shift_byte;
                                end
                                if (n_state.match_flag) begin
                                    n_state.drive_enable = 1'b1;
                                    n_state.drive_level  = 1'b0;
                                end
                            end else begin
                                n_state.drive_enable   = 1'b0;
                                n_state.transmit_index = i_state.transmit_index + 1'b1;
                            end
                            n_state.phase = i2csbe_pkg::PH_ACK;
                        end
                    end
                    i2csbe_pkg::PH_ACK: begin
                        n_state.bit_count = 4'd0;
                        if (!i_state.read_mode) begin
                            n_state.drive_enable = 1'b0;
                            n_state.first_byte   = 1'b0;
                            n_state.shift_byte   = 8'd0;
                        end else begin
                            n_state.drive_enable = 1'b1;
                            n_state.drive_level  = i_tx_data[7];
                        end
                        n_state.phase = i2csbe_pkg::PH_DATA;
                    end
                    i2csbe_pkg::PH_NACK: begin
                        n_state.bit_count    = 4'd0;
                        n_state.match_flag   = 1'b0;
                        n_state.drive_enable = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i_scl_level) begin
            // sda edge with scl high: start or stop
            if (!i_sda_level) begin
                n_state.phase = i2csbe_pkg::PH_START;
            end else begin
                n_state.phase      = i2csbe_pkg::PH_IDLE;
                n_state.match_flag = 1'b0;
                n_stop             = 1'b1;
            end
        end
    end

    // reported index is the low bits of the counter, zero extended
    assign n_index_wide = {5'd0, n_state.transmit_index};

    assign o_state = n_state;

    // result word
    always_comb begin
        o_result.sda_drive = n_state.drive_enable;
        o_result.sda_out   = n_state.drive_level;
        o_result.rx_valid  = n_rx_valid;
        o_result.rx_byte   = n_rx_byte;
        o_result.tx_index  = n_index_wide[i2csbe_pkg::TX_INDEX_OUT_BITS-1:0];
        o_result.stop_seen = n_stop;
        o_result.addressed = n_state.match_flag;
        o_result.bus_phase = n_state.phase;
    end

endmodule

`default_nettype wire

[rtl/i2c_slave_bit_engine.sv]
// Top level of the I2C slave bit engine: state and result registers around
// i2csbe_step. Uses i2csbe_pkg and the channel interfaces in i2csbe_ifs.sv.
//
//   channel   dir  word                                       accepted when
//   i_in      in   opcode, scl_level, sda_level, tx_data       valid && ready
//   o_out     out  sda_drive, sda_out, rx_valid, rx_byte,      valid && ready
//                  tx_index, stop_seen, addressed, bus_phase
//   i_cfg     in   own_address (7 bits)                        valid (ready tied high)
//
// One event per clock unless stalled; a result appears the cycle after its event.
// The single output register sets the rate: a new event is taken whenever that
// register is empty or is being read in the same cycle.
// Synchronous active-low reset clears the engine state, own address and the
// output valid. An output stall holds the result and stops intake.
`default_nettype none

module i2c_slave_bit_engine (
    input  wire               i_clk,
    input  wire               i_rst_n,
    i2csbe_in_if.sink         i_in,
    i2csbe_out_if.source      o_out,
    i2csbe_cfg_if.sink        i_cfg
);

    i2csbe_pkg::t_state  r_state;
    i2csbe_pkg::t_state  n_state;
    i2csbe_pkg::t_result r_result;
    i2csbe_pkg::t_result n_result;
    logic                r_out_valid;
    logic [6:0]          r_own_address;
    logic                w_in_ready;
    logic                w_in_take;

    // event update logic
    i2csbe_step u_step (
        .i_state       (r_state),
        .i_own_address (r_own_address),
        .i_opcode      (i_in.opcode),
        .i_scl_level   (i_in.scl_level),
        .i_sda_level   (i_in.sda_level),
        .i_tx_data     (i_in.tx_data),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // handshake
    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_in_take  = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    // own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= 7'd0;
        end else if (i_cfg.valid) begin
            r_own_address <= i_cfg.data;
        end
    end

    // engine state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2csbe_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_state <= n_state;
            end
            if (w_in_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_result <= n_result;
        end
    end

    // output channel
    assign o_out.valid     = r_out_valid;
    assign o_out.sda_drive = r_result.sda_drive;
    assign o_out.sda_out   = r_result.sda_out;
    assign o_out.rx_valid  = r_result.rx_valid;
    assign o_out.rx_byte   = r_result.rx_byte;
    assign o_out.tx_index  = r_result.tx_index;
    assign o_out.stop_seen = r_result.stop_seen;
    assign o_out.addressed = r_result.addressed;
    assign o_out.bus_phase = r_result.bus_phase;

endmodule

`default_nettype wire
